>>> rtl/rlpc_pkg.sv
// Shared constants, types and command word of the reflection-to-LPC converter.
`default_nettype none

package rlpc_pkg;

  localparam int unsigned NumCoeffs = 16;
  localparam int unsigned IdxW      = (NumCoeffs > 1) ? $clog2(NumCoeffs) : 1;
  localparam int unsigned OrdW      = $clog2(NumCoeffs + 1);
  localparam int unsigned ReflW     = 16;
  localparam int unsigned CoeffW    = 32;
  localparam int unsigned OutIdxW   = 6;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = 2 * CoeffW;
  localparam int unsigned DiffW     = ProdW - FracW + 1;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_NEG,
    WSEL_DIFF_A,
    WSEL_DIFF_B
  } wsel_e;

  typedef struct packed {
    logic            we;
    wsel_e           wsel;
    logic [IdxW-1:0] waddr;
    logic            rd_en;
    logic [IdxW-1:0] raddr_a;
    logic [IdxW-1:0] raddr_b;
    logic            k_ld;
    logic            mul_en;
    logic            mul_sel_b;
    logic            out_issue;
    logic            out_last;
    logic [IdxW-1:0] out_idx;
  } rlpc_cmd_t;

endpackage

`default_nettype wire

>>> rtl/rlpc_ctrl.sv
// Sequencer for load, step-up recursion and readout of the converter.
`default_nettype none

module rlpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output rlpc_pkg::rlpc_cmd_t cmd_o
);
  import rlpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_RD,
    ST_NEG_WR,
    ST_PAIR_RD,
    ST_PAIR_M1,
    ST_PAIR_M2,
    ST_PAIR_W2,
    ST_OUT
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [OrdW-1:0] m_q, m_d;
  logic [OrdW-1:0] j_q, j_d;
  logic [OrdW-1:0] j_inc;
  logic [OrdW-1:0] m_minus_j;
  logic            last_cnt;
  logic            last_ord;
  logic            more_pairs;

  function automatic logic [IdxW-1:0] r_addr(input logic [OrdW-1:0] i);
    logic [OrdW-1:0] diff;
    diff = OrdW'(NumCoeffs) - i;
    return diff[IdxW-1:0];
  endfunction

  assign last_cnt   = (cnt_q == IdxW'(NumCoeffs - 1));
  assign last_ord   = (m_q == OrdW'(NumCoeffs));
  assign j_inc      = j_q + OrdW'(1);
  assign m_minus_j  = m_q - j_q;
  assign more_pairs = ({j_inc, 1'b0} <= {1'b0, m_q});
  assign busy_o     = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    j_d     = j_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.we    = 1'b1;
          cmd_o.wsel  = WSEL_LOAD;
          cmd_o.waddr = cnt_q;
          if (last_cnt) begin
            cnt_d   = '0;
            m_d     = OrdW'(1);
            state_d = ST_NEG_RD;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      ST_NEG_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.raddr_a = r_addr(m_q);
        state_d       = ST_NEG_WR;
      end
      ST_NEG_WR: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsel  = WSEL_NEG;
        cmd_o.waddr = r_addr(m_q);
        cmd_o.k_ld  = 1'b1;
        if (m_q > OrdW'(1)) begin
          j_d     = OrdW'(1);
          state_d = ST_PAIR_RD;
        end else if (last_ord) begin
          state_d = ST_OUT;
        end else begin
          m_d     = m_q + OrdW'(1);
          state_d = ST_NEG_RD;
        end
      end
      ST_PAIR_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.raddr_a = r_addr(j_q);
        cmd_o.raddr_b = r_addr(m_minus_j);
        state_d       = ST_PAIR_M1;
      end
      ST_PAIR_M1: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel_b = 1'b1;
        state_d         = ST_PAIR_M2;
      end
      ST_PAIR_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.we     = 1'b1;
        cmd_o.wsel   = WSEL_DIFF_A;
        cmd_o.waddr  = r_addr(j_q);
        state_d      = ST_PAIR_W2;
      end
      ST_PAIR_W2: begin
        cmd_o.we    = 1'b1;
        cmd_o.wsel  = WSEL_DIFF_B;
        cmd_o.waddr = r_addr(m_minus_j);
        if (more_pairs) begin
          j_d     = j_inc;
          state_d = ST_PAIR_RD;
        end else if (last_ord) begin
          state_d = ST_OUT;
        end else begin
          m_d     = m_q + OrdW'(1);
          state_d = ST_NEG_RD;
        end
      end
      ST_OUT: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.raddr_a   = cnt_q;
        cmd_o.out_issue = 1'b1;
        cmd_o.out_idx   = cnt_q;
        cmd_o.out_last  = last_cnt;
        if (last_cnt) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      m_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      m_q     <= m_d;
      j_q     <= j_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxW'(NumCoeffs - 1))
    else $error("word counter beyond frame");

  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAIR_RD) |-> ((j_q != '0) && ({j_q, 1'b0} <= {1'b0, m_q})))
    else $error("pair index outside half order");

  a_out_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && last_cnt) |=> (state_q == ST_IDLE))
    else $error("readout did not finish on last word");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.we && cmd_o.wsel == WSEL_LOAD) |-> (start_i && state_q == ST_IDLE))
    else $error("load write outside accepted word");

endmodule

`default_nettype wire

>>> rtl/rlpc_datapath.sv
// Coefficient store, shared multiplier and saturating update datapath.
`default_nettype none

module rlpc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rlpc_pkg::rlpc_cmd_t                 cmd_i,
  input  logic signed [rlpc_pkg::ReflW-1:0]   refl_coeff_i,
  output logic                                valid_o,
  output logic signed [rlpc_pkg::CoeffW-1:0]  lpc_coeff_o,
  output logic        [rlpc_pkg::OutIdxW-1:0] coeff_index_o,
  output logic                                last_of_frame_o
);
  import rlpc_pkg::*;

  localparam logic signed [DiffW-1:0] MaxV =
    {{(DiffW - CoeffW + 1){1'b0}}, {(CoeffW - 1){1'b1}}};
  localparam logic signed [DiffW-1:0] MinV =
    {{(DiffW - CoeffW + 1){1'b1}}, {(CoeffW - 1){1'b0}}};
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) << (FracW - 1);

  logic        [CoeffW-1:0] store_q [NumCoeffs];
  logic signed [CoeffW-1:0] rd_a_q, rd_b_q, k_q;
  logic signed [ProdW-1:0]  prod_q, prod_d, prod_rnd;
  logic signed [CoeffW-1:0] mul_op;
  logic signed [CoeffW-1:0] load_val, neg_val, diff_val, wdata;
  logic signed [CoeffW-1:0] diff_base;
  logic signed [DiffW-1:0]  neg_wide, diff_wide, prod_scaled;
  logic                     valid_q, last_q;
  logic        [IdxW-1:0]   idx_q;

  function automatic logic signed [CoeffW-1:0] sat_coeff(input logic signed [DiffW-1:0] v);
    logic signed [CoeffW-1:0] r;
    if (v > MaxV) begin
      r = MaxV[CoeffW-1:0];
    end else if (v < MinV) begin
      r = MinV[CoeffW-1:0];
    end else begin
      r = v[CoeffW-1:0];
    end
    return r;
  endfunction

  assign load_val = {{(CoeffW - ReflW - 1){refl_coeff_i[ReflW-1]}}, refl_coeff_i, 1'b0};

  assign neg_wide = -DiffW'(rd_a_q);
  assign neg_val  = sat_coeff(neg_wide);

  assign mul_op = cmd_i.mul_sel_b ? rd_b_q : rd_a_q;
  assign prod_d = mul_op * k_q;

  assign prod_rnd    = prod_q + RndHalf;
  assign prod_scaled = DiffW'($signed(prod_rnd[ProdW-1:FracW]));
  assign diff_base   = (cmd_i.wsel == WSEL_DIFF_A) ? rd_a_q : rd_b_q;
  assign diff_wide   = DiffW'(diff_base) - prod_scaled;
  assign diff_val    = sat_coeff(diff_wide);

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_LOAD:   wdata = load_val;
      WSEL_NEG:    wdata = neg_val;
      WSEL_DIFF_A: wdata = diff_val;
      WSEL_DIFF_B: wdata = diff_val;
      default:     wdata = diff_val;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      store_q[cmd_i.waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= store_q[cmd_i.raddr_a];
      rd_b_q <= store_q[cmd_i.raddr_b];
    end
    if (cmd_i.k_ld) begin
      k_q <= neg_val;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    idx_q <= cmd_i.out_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_issue;
      last_q  <= cmd_i.out_issue & cmd_i.out_last;
    end
  end

  assign valid_o         = valid_q;
  assign lpc_coeff_o     = rd_a_q;
  assign coeff_index_o   = OutIdxW'(idx_q);
  assign last_of_frame_o = last_q;

endmodule

`default_nettype wire

>>> rtl/reflection_to_lpc_converter_core.sv
// Top level of the reflection-to-LPC converter: controller plus datapath.
// Loading: one word per cycle while start_i is high and busy_o low; the last raises busy_o.
// Recursion: per order, read and negate k; per pair, read both, two products, two writes.
// Readout: one result per cycle after the recursion; strobe and word are registered.
// Frame of 16: a new frame is taken only once readout of the previous one has ended.
// Reset clears the controller and the strobe; the coefficient store is not cleared.
`default_nettype none

module reflection_to_lpc_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rlpc_pkg::ReflW-1:0]   refl_coeff_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output logic signed [rlpc_pkg::CoeffW-1:0]  lpc_coeff_o,
  output logic        [rlpc_pkg::OutIdxW-1:0] coeff_index_o,
  output logic                                last_of_frame_o
);
  import rlpc_pkg::*;

  rlpc_cmd_t cmd;

  rlpc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  rlpc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .refl_coeff_i    (refl_coeff_i),
    .valid_o         (valid_o),
    .lpc_coeff_o     (lpc_coeff_o),
    .coeff_index_o   (coeff_index_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire
